@@ design/ssp_pkg.sv @@
// ----------------------------------------------------------------------------
// ssp_pkg - shared types and constants of the stack function scratchpad placer
// Request/result payloads, table entry layout, controller commands and status,
// and the circular range overlap test.
// ----------------------------------------------------------------------------
package ssp_pkg;

    // Table geometry
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Positions and sizes inside the scratchpad
    localparam int POS_W = 17;
    localparam int DIV_W = POS_W + 1;
    localparam int SUM_W = POS_W + CNT_W;
    localparam int STEP_W = $clog2(DIV_W + 1);

    localparam logic [POS_W-1:0] MEM_MAX    = 17'd65536;
    localparam logic [POS_W-1:0] MEM_RESET  = 17'd4096;
    localparam logic [POS_W-1:0] USED_MAX   = 17'h1FFFF;

    // Configuration port
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE   = 1'b1;

    typedef enum logic [2:0] {
        ST_RESIDENT = 3'd0,
        ST_PLACED   = 3'd1,
        ST_OVR_IGN  = 3'd2,
        ST_OVR_ERR  = 3'd3,
        ST_NO_PRED  = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    typedef struct packed {
        logic        req_type;
        logic [31:0] target_addr;
        logic [19:0] func_size;
        logic [31:0] pred_addr;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [16:0] place_begin;
        logic [16:0] place_end;
        logic [4:0]  evicted_count;
        logic [16:0] used_bytes;
        logic [4:0]  entry_count;
    } t_res;

    typedef struct packed {
        logic [31:0]      addr;
        logic [POS_W-1:0] pbeg;
        logic [POS_W-1:0] pend;
        logic [POS_W-1:0] bytes;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_MOD,
        S_OVL,
        S_FIN
    } t_state;

    typedef struct packed {
        logic    load;
        logic    walk_en;
        logic    walk_clr;
        logic    scan;
        logic    ovl;
        logic    mod_start;
        logic    set_range;
        logic    commit;
        logic    finish;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic oversize;
        logic ignore;
        logic hit;
        logic pfound;
        logic empty;
        logic is_ret;
        logic walk_done;
        logic mod_done;
        logic full_no_evict;
    } t_stat;

    // Circular ranges [ab, ae) and [bb, be) modulo m share at least one byte
    function automatic logic ranges_overlap(
        input logic [POS_W-1:0] ab,
        input logic [POS_W-1:0] ae,
        input logic [POS_W-1:0] bb,
        input logic [POS_W-1:0] be,
        input logic [POS_W-1:0] m
    );
        logic           wa;
        logic           wb;
        logic [POS_W:0] a_lim;
        logic [POS_W:0] b_lim;
        logic           a_in_b;
        logic           b_in_a;
        wa     = ab > ae;
        wb     = bb > be;
        a_lim  = wa ? ({1'b0, ae} + {1'b0, m}) : {1'b0, ae};
        b_lim  = wb ? ({1'b0, be} + {1'b0, m}) : {1'b0, be};
        a_in_b = (ab >= bb) && (({1'b0, ab} < b_lim) || (wa && (ae > bb)));
        b_in_a = (bb >= ab) && (({1'b0, bb} < a_lim) || (wb && (be > ab)));
        return a_in_b || b_in_a;
    endfunction

    // Clamp a table count to the 5-bit result field
    function automatic logic [4:0] sat_cnt(input logic [CNT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w > 32'd31) begin
            return 5'd31;
        end
        return w[4:0];
    endfunction

endpackage

@@ design/ssp_mod.sv @@
// ----------------------------------------------------------------------------
// ssp_mod - serial remainder unit
// Restoring remainder of an 18-bit dividend by a 17-bit modulus, one
// dividend bit per cycle; pulses done when the remainder is valid.
// ----------------------------------------------------------------------------
module ssp_mod
    import ssp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [POS_W-1:0] i_modulus,
    output logic             o_done,
    output logic [POS_W-1:0] o_rem
);

    logic              r_run;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIV_W-1:0]  r_div;
    logic [POS_W-1:0]  r_mod;
    logic [POS_W-1:0]  r_rem;
    logic [DIV_W-1:0]  trial;
    logic [POS_W-1:0]  n_rem;

    // Shift in the next dividend bit and subtract when it fits
    always_comb begin
        trial = {r_rem, r_div[DIV_W-1]};
        if (trial >= {1'b0, r_mod}) begin
            n_rem = POS_W'(trial - {1'b0, r_mod});
        end else begin
            n_rem = trial[POS_W-1:0];
        end
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DIV_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Hold operands and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_dividend;
            r_mod <= i_modulus;
            r_rem <= '0;
        end else if (r_run) begin
            r_div <= {r_div[DIV_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ design/ssp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssp_ctrl - placement sequencer
// Steps one activation through size check, residency scan, position
// computation, overlap scan and table update.
// ----------------------------------------------------------------------------
module ssp_ctrl
    import ssp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state;
    t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_stat.oversize ? S_IDLE : S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    n_state = S_IDLE;
                end else if (i_stat.walk_done) begin
                    if (i_stat.empty && !i_stat.is_ret) n_state = S_OVL;
                    else if (!i_stat.pfound)            n_state = S_IDLE;
                    else                                n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (i_stat.mod_done) n_state = S_OVL;
            end
            S_OVL: begin
                if (i_stat.walk_done) n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd        = '0;
        o_cmd.status = ST_RESIDENT;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
            end
            S_CHECK: begin
                if (i_stat.oversize) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = i_stat.ignore ? ST_OVR_IGN : ST_OVR_ERR;
                end
            end
            S_SCAN: begin
                o_cmd.walk_en = 1'b1;
                o_cmd.scan    = 1'b1;
                if (i_stat.hit) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_RESIDENT;
                end else if (i_stat.walk_done) begin
                    if (i_stat.empty && !i_stat.is_ret) begin
                        o_cmd.set_range = 1'b1;
                        o_cmd.walk_clr  = 1'b1;
                    end else if (!i_stat.pfound) begin
                        o_cmd.finish = 1'b1;
                        o_cmd.status = ST_NO_PRED;
                    end else begin
                        o_cmd.mod_start = 1'b1;
                    end
                end
            end
            S_MOD: begin
                if (i_stat.mod_done) begin
                    o_cmd.set_range = 1'b1;
                    o_cmd.walk_clr  = 1'b1;
                end
            end
            S_OVL: begin
                o_cmd.walk_en = 1'b1;
                o_cmd.ovl     = 1'b1;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                if (i_stat.full_no_evict) begin
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.status = ST_PLACED;
                    o_cmd.commit = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ design/ssp_dp.sv @@
// ----------------------------------------------------------------------------
// ssp_dp - placer datapath
// Configuration registers, function table memory with valid bits, table
// walk with residency and overlap tests, and the result register.
// ----------------------------------------------------------------------------
module ssp_dp
    import ssp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_req                 i_req,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output t_res                 o_res,
    output logic                 o_valid
);

    // Configuration
    logic [POS_W-1:0] r_capacity;
    logic             r_ignore;

    // Current request
    t_req             r_req;
    logic [POS_W-1:0] r_m;
    logic [POS_W-1:0] eff_m;
    logic [POS_W-1:0] size17;

    // Table
    t_entry                 mem [MAX_ENTRIES];
    t_entry                 r_rd;
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]       r_cnt;
    logic [POS_W-1:0]       r_used;

    // Walk
    logic [CNT_W-1:0] r_ra;
    logic             r_rv;
    logic [IDX_W-1:0] r_ri;
    logic             ent_ok;
    logic             walk_done;

    // Scan and overlap results
    logic                   r_hit;
    logic                   r_pfound;
    logic [POS_W-1:0]       r_pbeg;
    logic [POS_W-1:0]       r_pend;
    logic [POS_W-1:0]       r_nb;
    logic [POS_W-1:0]       r_ne;
    logic [MAX_ENTRIES-1:0] r_evict;
    logic [CNT_W-1:0]       r_ev;
    logic [SUM_W-1:0]       r_sum;

    // Remainder unit
    logic [DIV_W-1:0] dividend;
    logic             mod_done;
    logic [POS_W-1:0] mod_rem;

    // Commit values
    logic [MAX_ENTRIES-1:0] free_vec;
    logic [IDX_W-1:0]       free_idx;
    logic [SUM_W-1:0]       sum_new;
    logic [POS_W-1:0]       used_new;
    logic [CNT_W-1:0]       cnt_new;

    t_res r_res;
    logic r_out_vld;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= MEM_RESET;
            r_ignore   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CAPACITY: r_capacity <= i_cfg_data;
                CFG_IGNORE:   r_ignore   <= i_cfg_data[0];
                default:      r_ignore   <= r_ignore;
            endcase
        end
    end

    // Clamp capacity to the supported range
    always_comb begin
        if (r_capacity == '0)         eff_m = POS_W'(1);
        else if (r_capacity > MEM_MAX) eff_m = MEM_MAX;
        else                          eff_m = r_capacity;
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_m   <= eff_m;
        end
    end

    assign size17 = r_req.func_size[POS_W-1:0];

    // Table memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            mem[free_idx] <= '{addr: r_req.target_addr, pbeg: r_nb, pend: r_ne, bytes: size17};
        end
        r_rd <= mem[r_ra[IDX_W-1:0]];
    end

    // Advance the table walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ra <= '0;
            r_rv <= 1'b0;
        end else if (i_cmd.load || i_cmd.walk_clr) begin
            r_ra <= '0;
            r_rv <= 1'b0;
        end else if (i_cmd.walk_en && (r_ra != CNT_W'(MAX_ENTRIES))) begin
            r_ra <= r_ra + 1'b1;
            r_rv <= 1'b1;
        end else begin
            r_rv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ri <= r_ra[IDX_W-1:0];
    end

    assign ent_ok    = r_rv && r_valid[r_ri];
    assign walk_done = (r_ra == CNT_W'(MAX_ENTRIES)) && !r_rv;

    // Residency scan: find a hit and the first predecessor entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit    <= 1'b0;
            r_pfound <= 1'b0;
        end else if (i_cmd.load) begin
            r_hit    <= 1'b0;
            r_pfound <= 1'b0;
        end else if (i_cmd.scan && ent_ok) begin
            if (r_rd.addr == r_req.target_addr) r_hit <= 1'b1;
            if (!r_pfound && (r_rd.addr == r_req.pred_addr)) r_pfound <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && ent_ok && !r_pfound && (r_rd.addr == r_req.pred_addr)) begin
            r_pbeg <= r_rd.pbeg;
            r_pend <= r_rd.pend;
        end
    end

    // Position after (call) or before (return) the predecessor
    assign dividend = r_req.req_type
        ? DIV_W'({1'b0, r_pbeg} + {1'b0, r_m} - {1'b0, size17})
        : DIV_W'({1'b0, r_pend} + {1'b0, size17});

    ssp_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend (dividend),
        .i_modulus  (r_m),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // Set the new range
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_range) begin
            if ((r_cnt == '0) && !r_req.req_type) begin
                r_nb <= '0;
                r_ne <= size17;
            end else if (!r_req.req_type) begin
                r_nb <= r_pend;
                r_ne <= mod_rem;
            end else begin
                r_nb <= mod_rem;
                r_ne <= r_pbeg;
            end
        end
    end

    // Overlap scan: mark evictions, sum the surviving sizes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evict <= '0;
            r_ev    <= '0;
            r_sum   <= '0;
        end else if (i_cmd.walk_clr) begin
            r_evict <= '0;
            r_ev    <= '0;
            r_sum   <= '0;
        end else if (i_cmd.ovl && ent_ok) begin
            if (ranges_overlap(r_nb, r_ne, r_rd.pbeg, r_rd.pend, r_m)) begin
                r_evict[r_ri] <= 1'b1;
                r_ev          <= r_ev + 1'b1;
            end else begin
                r_sum <= r_sum + SUM_W'(r_rd.bytes);
            end
        end
    end

    // Lowest free slot after evictions
    assign free_vec = ~r_valid | r_evict;
    always_comb begin
        free_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (free_vec[i]) free_idx = IDX_W'(i);
        end
    end

    assign sum_new  = r_sum + SUM_W'(size17);
    assign used_new = (sum_new > SUM_W'(USED_MAX)) ? USED_MAX : sum_new[POS_W-1:0];
    assign cnt_new  = r_cnt - r_ev + 1'b1;

    // Update valid bits and table totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_cnt   <= '0;
            r_used  <= '0;
        end else if (i_cmd.commit) begin
            r_valid <= (r_valid & ~r_evict) | (MAX_ENTRIES'(1) << free_idx);
            r_cnt   <= cnt_new;
            r_used  <= used_new;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res.status <= i_cmd.status;
            if (i_cmd.commit) begin
                r_res.place_begin   <= r_nb;
                r_res.place_end     <= r_ne;
                r_res.evicted_count <= sat_cnt(r_ev);
                r_res.used_bytes    <= used_new;
                r_res.entry_count   <= sat_cnt(cnt_new);
            end else begin
                r_res.place_begin   <= '0;
                r_res.place_end     <= '0;
                r_res.evicted_count <= '0;
                r_res.used_bytes    <= r_used;
                r_res.entry_count   <= sat_cnt(r_cnt);
            end
        end
    end

    // Status to the controller
    always_comb begin
        o_stat.oversize      = r_req.func_size > {3'b000, r_m};
        o_stat.ignore        = r_ignore;
        o_stat.hit           = r_hit;
        o_stat.pfound        = r_pfound;
        o_stat.empty         = (r_cnt == '0);
        o_stat.is_ret        = r_req.req_type;
        o_stat.walk_done     = walk_done;
        o_stat.mod_done      = mod_done;
        o_stat.full_no_evict = (r_cnt == CNT_W'(MAX_ENTRIES)) && (r_ev == '0);
    end

    assign o_res   = r_res;
    assign o_valid = r_out_vld;

endmodule

@@ design/stack_function_scratchpad_placer.sv @@
// ----------------------------------------------------------------------------
// stack_function_scratchpad_placer - stack-ordered scratchpad function placer
// Oversize requests finish after the size check and a hit during the table
// scan; a missing predecessor finishes after the scan, a first call into an
// empty table skips the remainder step, and any other placement or full table
// takes two table walks over one read port plus an 18-step remainder.
// Throughput: one activation at a time; busy stays high until the result is
// issued, o_valid pulses for one cycle. Synchronous active-low reset empties
// the table and loads a 4096-byte capacity with oversized functions ignored.
// ----------------------------------------------------------------------------
module stack_function_scratchpad_placer
    import ssp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  t_req                 i_req,
    output logic                 busy,
    output logic                 o_valid,
    output t_res                 o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;
    logic  ctrl_busy;
    logic  accept;

    // Transfer a request only while no activation is in flight
    assign accept = start && !ctrl_busy;

    ssp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (ctrl_busy)
    );

    ssp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_res      (o_res),
        .o_valid    (o_valid)
    );

    assign busy = ctrl_busy;

endmodule

@@ dv/stack_function_scratchpad_placer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_function_scratchpad_placer_tb - self-checking bench for the placer
// Drives call and return activations through the start/busy command port,
// mirrors the resident table in a scoreboard, and compares every result
// strobe field by field. Walks several scratchpad sizes and oversize modes,
// including zero and out-of-range sizes, with random gaps on the sender.
// ----------------------------------------------------------------------------
import ssp_pkg::*;

// Track the resident table, predict each result and check it on arrival
class placement_board;
    logic [16:0] mem_reg;
    bit          ignore_reg;
    bit          live     [MAX_ENTRIES];
    logic [31:0] owner    [MAX_ENTRIES];
    int unsigned span_beg [MAX_ENTRIES];
    int unsigned span_end [MAX_ENTRIES];
    int unsigned span_len [MAX_ENTRIES];
    t_res        awaited  [$];
    int          failures;

    function new();
        mem_reg    = MEM_RESET;
        ignore_reg = 1'b1;
        failures   = 0;
        foreach (live[i]) begin
            live[i] = 1'b0;
        end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        if (idx == CFG_CAPACITY) begin
            mem_reg = data;
        end else if (idx == CFG_IGNORE) begin
            ignore_reg = data[0];
        end
    endfunction

    // Effective modulus: zero acts as one, anything above 64 KiB is clipped
    function int unsigned ring_size();
        if (mem_reg == 0) begin
            return 1;
        end
        if (mem_reg > 17'd65536) begin
            return 65536;
        end
        return mem_reg;
    endfunction

    function bit pick_resident(output logic [31:0] a);
        int idx [$];
        foreach (live[i]) begin
            if (live[i]) begin
                idx.push_back(i);
            end
        end
        a = '0;
        if (idx.size() == 0) begin
            return 1'b0;
        end
        a = owner[idx[$urandom_range(0, idx.size() - 1)]];
        return 1'b1;
    endfunction

    // Circular ranges [ab, ae) and [bb, be) share a byte
    function bit spans_collide(int unsigned ab, int unsigned ae, int unsigned bb,
                               int unsigned be, int unsigned m);
        bit          wa;
        bit          wb;
        int unsigned a_lim;
        int unsigned b_lim;
        wa    = ab > ae;
        wb    = bb > be;
        a_lim = wa ? ae + m : ae;
        b_lim = wb ? be + m : be;
        if (ab >= bb && (ab < b_lim || (wa && ae > bb))) begin
            return 1'b1;
        end
        if (bb >= ab && (bb < a_lim || (wb && be > ab))) begin
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Summarize the table after the step and queue the outcome
    function void queue_result(t_status st, int unsigned pb, int unsigned pe,
                               int unsigned ev);
        t_res        r;
        int unsigned used;
        int unsigned cnt;
        used = 0;
        cnt  = 0;
        foreach (live[i]) begin
            if (live[i]) begin
                used += span_len[i];
                if (used > USED_MAX) begin
                    used = USED_MAX;
                end
                cnt++;
            end
        end
        if (cnt > 31) begin
            cnt = 31;
        end
        if (ev > 31) begin
            ev = 31;
        end
        r.status        = st;
        r.place_begin   = 17'(pb);
        r.place_end     = 17'(pe);
        r.evicted_count = 5'(ev);
        r.used_bytes    = 17'(used);
        r.entry_count   = 5'(cnt);
        awaited.push_back(r);
    endfunction

    // Apply one accepted activation to the table
    function void note_activation(t_req rq);
        int unsigned m;
        int unsigned size;
        int unsigned nb;
        int unsigned ne;
        int unsigned count;
        int unsigned ev;
        int          pred_i;
        int          free_i;
        bit          evict [MAX_ENTRIES];
        m      = ring_size();
        size   = rq.func_size;
        nb     = 0;
        ne     = 0;
        count  = 0;
        ev     = 0;
        pred_i = -1;
        free_i = -1;
        if (size > m) begin
            queue_result(ignore_reg ? ST_OVR_IGN : ST_OVR_ERR, 0, 0, 0);
            return;
        end
        foreach (live[i]) begin
            if (live[i]) begin
                count++;
                if (owner[i] == rq.target_addr) begin
                    queue_result(ST_RESIDENT, 0, 0, 0);
                    return;
                end
                if (pred_i < 0 && owner[i] == rq.pred_addr) begin
                    pred_i = i;
                end
            end
        end
        if (count == 0 && !rq.req_type) begin
            ne = size;
        end else if (pred_i < 0) begin
            queue_result(ST_NO_PRED, 0, 0, 0);
            return;
        end else if (!rq.req_type) begin
            nb = span_end[pred_i];
            ne = (nb + size) % m;
        end else begin
            ne = span_beg[pred_i];
            nb = (ne + m - size) % m;
        end
        foreach (live[i]) begin
            evict[i] = live[i] && spans_collide(nb, ne, span_beg[i], span_end[i], m);
            if (evict[i]) begin
                ev++;
            end
        end
        if (count >= MAX_ENTRIES && ev == 0) begin
            queue_result(ST_FULL, 0, 0, 0);
            return;
        end
        // Drop overlapped entries, then take the lowest free slot
        foreach (live[i]) begin
            if (evict[i]) begin
                live[i] = 1'b0;
            end
            if (free_i < 0 && !live[i]) begin
                free_i = i;
            end
        end
        if (free_i >= 0) begin
            live[free_i]     = 1'b1;
            owner[free_i]    = rq.target_addr;
            span_beg[free_i] = nb;
            span_end[free_i] = ne;
            span_len[free_i] = size;
        end
        queue_result(ST_PLACED, nb, ne, ev);
    endfunction

    function void compare_field(string name, logic [16:0] want, logic [16:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    function void check_result(t_res got);
        t_res want;
        if (awaited.size() == 0) begin
            $error("result strobe with no activation outstanding");
            failures++;
            return;
        end
        want = awaited.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("place_begin", want.place_begin, got.place_begin);
        compare_field("place_end", want.place_end, got.place_end);
        compare_field("evicted_count", want.evicted_count, got.evicted_count);
        compare_field("used_bytes", want.used_bytes, got.used_bytes);
        compare_field("entry_count", want.entry_count, got.entry_count);
    endfunction
endclass

module stack_function_scratchpad_placer_tb;

    localparam bit REQ_CALL       = 1'b0;
    localparam bit REQ_RETURN     = 1'b1;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 106;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 70;

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    t_req                 i_req      = '0;
    logic                 busy;
    logic                 o_valid;
    t_res                 o_res;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = CFG_CAPACITY;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    placement_board board = new();
    logic [31:0]    last_addr = '0;
    int             idle_cycles = 0;

    // Scratchpad sizes and oversize modes per phase, extremes included
    logic [16:0] phase_mem [PHASES] = '{17'd4096, 17'd64, 17'd1, 17'd0, 17'd65536,
                                        17'd131071, 17'd300, 17'd65537, 17'd1024,
                                        17'd17, 17'd4096, 17'd2048};
    bit          phase_ign [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                                        1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    stack_function_scratchpad_placer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req      (i_req),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Check each result strobe against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            board.check_result(o_res);
        end
    end

    // Abort when no transfer happens in either direction for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Back to back when quiet, else often back to back or a short gap, rarely a long pause
    function automatic int gap_len(bit quiet);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (quiet || sel < 40) begin
            return 0;
        end
        if (sel < 85) begin
            return $urandom_range(1, 3);
        end
        if (sel < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(16, 60);
    endfunction

    // Hold one activation on the port until the block takes it
    task automatic activate(input bit ret, input logic [31:0] a, input logic [19:0] sz,
                            input logic [31:0] pr, input int gap);
        t_req rq;
        rq.req_type    = ret;
        rq.target_addr = a;
        rq.func_size   = sz;
        rq.pred_addr   = pr;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= rq;
        do @(posedge i_clk); while (busy);
        board.note_activation(rq);
        last_addr = a;
    endtask

    // Drop start and wait until every predicted result has come back
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (board.awaited.size() != 0 || busy);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [16:0] mem, input bit ign);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CAPACITY;
        i_cfg_data <= mem;
        @(posedge i_clk);
        board.set_reg(CFG_CAPACITY, mem);
        i_cfg_idx  <= CFG_IGNORE;
        i_cfg_data <= 17'(ign);
        @(posedge i_clk);
        board.set_reg(CFG_IGNORE, 17'(ign));
        i_cfg_we   <= 1'b0;
    endtask

    // Hand-picked cases at the reset configuration
    task automatic directed_cases();
        logic [31:0] chain [17];
        for (int i = 0; i < 17; i++) begin
            chain[i] = (i == 0) ? 32'h0 : 32'h0001_0000 + i;
        end
        // Return into an empty table has no predecessor
        activate(REQ_RETURN, 32'h5555_0000, 20'd8, 32'h0, 0);
        // First call lands at position zero, then chain sixteen entries
        activate(REQ_CALL, chain[0], 20'd16, 32'hFFFF_FFFF, 0);
        for (int i = 1; i < 16; i++) begin
            activate(REQ_CALL, chain[i], 20'd16, chain[i-1], 0);
        end
        // Free space after the tail but no free slot
        activate(REQ_CALL, chain[16], 20'd16, chain[15], 0);
        activate(REQ_RETURN, chain[3], 20'd16, chain[0], 0);
        activate(REQ_CALL, 32'h6000_0000, 20'd4097, chain[15], 0);
        activate(REQ_CALL, 32'h6000_0001, 20'hFFFFF, chain[15], 0);
        activate(REQ_RETURN, 32'h6000_0002, 20'd10, 32'hFFFF_FFFF, 0);
        // Return wrapping below zero, then a wide call wrapping past the end
        activate(REQ_RETURN, 32'h6000_0003, 20'd100, chain[0], 0);
        activate(REQ_CALL, 32'h6000_0004, 20'd4000, chain[7], 0);
        activate(REQ_RETURN, 32'hFFFF_FFFF, 20'd0, chain[4], 0);
    endtask

    // Mostly well-formed chains off resident functions, some noise
    task automatic random_activation(input bit quiet);
        int unsigned m;
        int unsigned sel;
        int unsigned size;
        logic [31:0] a;
        logic [31:0] pr;
        logic [31:0] pick;
        bit          found;
        m   = board.ring_size();
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            size = $urandom_range(0, m / 32);
        end else if (sel < 75) begin
            size = $urandom_range(0, m / 4);
        end else if (sel < 85) begin
            size = $urandom_range(0, m);
        end else if (sel < 90) begin
            size = m;
        end else begin
            size = $urandom_range(0, 20'hFFFFF);
        end
        sel   = $urandom_range(0, 99);
        found = board.pick_resident(pick);
        if (sel < 12 && found) begin
            a = pick;
        end else if (sel < 55) begin
            a = 32'h4000_0000 | $urandom_range(0, 63);
        end else begin
            a = $urandom;
        end
        sel   = $urandom_range(0, 99);
        found = board.pick_resident(pick);
        if (sel < 50) begin
            pr = last_addr;
        end else if (sel < 85 && found) begin
            pr = pick;
        end else begin
            pr = $urandom;
        end
        activate(($urandom_range(0, 99) < 40) ? REQ_RETURN : REQ_CALL, a, 20'(size),
                 pr, gap_len(quiet));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_cases();
        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_config(phase_mem[p], phase_ign[p]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Occasionally let the pipeline drain before the next transfer
                if ($urandom_range(0, 49) == 0) begin
                    settle();
                end
                random_activation(p % 3 == 0);
            end
        end
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.awaited.size() != 0) begin
            $error("%0d results never arrived", board.awaited.size());
            board.failures++;
        end
        if (board.failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
